// File: rtl/rbt_pkg.sv
// Shared constants and types for the relay bank auto-off timer.
`timescale 1ns / 1ps
`default_nettype none

package rbt_pkg;

    // Number of relay sockets driven by the block (1 to 16).
    localparam int SOCKETS     = 6;
    localparam int MAX_SOCKETS = 16;
    localparam int SOCK_W      = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

    // Configuration registers: one minutes value per socket 0 to 5.
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    // Payload widths fixed by the interface.
    localparam int SOCKET_W  = 3;
    localparam int ENABLED_W = 8;
    localparam int OUT_W     = 6;
    localparam int CNT_W     = 16;

    localparam logic [CNT_W-1:0]     CNT_STOPPED = 16'hFFFF;
    localparam logic [ENABLED_W-1:0] VAL_ON      = 8'd1;

    // Command codes.
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TICK = 4'b0010,
        ST_SET  = 4'b0100,
        ST_EMIT = 4'b1000
    } rbt_state_t;

    // Countdown load for a socket: minutes times 60 ticks, as two shifts.
    function automatic logic [CNT_W-1:0] minutes_to_ticks(input logic [CFG_W-1:0] minutes);
        logic [CNT_W-1:0] m;
        m = CNT_W'(minutes);
        return (m << 6) - (m << 2);
    endfunction

endpackage

`default_nettype wire

// File: rtl/relay_bank_auto_off_timer.sv
// Top level of the relay bank with per-socket auto-off countdowns.
`timescale 1ns / 1ps
`default_nettype none

// Relay bank with one auto-off countdown per socket. A set request (cmd 0)
// passes through the set and emit states and a tick request (cmd 1) through
// one tick state per socket and then the emit state before the next request
// can be accepted; the result is registered as the emit state is left. A tick
// is slow because one shared decrement-and-compare unit walks the countdown
// registers one socket per cycle under a small sequencer. The
// input side stalls while a request is in work; a finished result sits in an
// output register, so a new request can be accepted while the previous result
// is still waiting to be taken. A result that is held off by the output stall
// keeps the next request in its final step until the output register frees.
// Configuration writes are taken at any time but should be made while idle.
module relay_bank_auto_off_timer
    import rbt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [SOCKET_W-1:0]  socket,
    input  wire logic [ENABLED_W-1:0] enabled,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [OUT_W-1:0]          relay_state,
    output logic [OUT_W-1:0]          expired_mask,
    output logic                      applied_value
);

    rbt_state_t state_reg, state_next;

    logic [CFG_W-1:0]     min_reg [NUM_CFG];
    logic [CNT_W-1:0]     cnt_reg [SOCKETS];
    logic [CNT_W-1:0]     cnt_next [SOCKETS];
    logic [SOCKETS-1:0]   relay_reg, relay_next;
    logic [SOCKETS-1:0]   exp_reg, exp_next;
    logic                 applied_reg, applied_next;
    logic [SOCK_W-1:0]    idx_reg, idx_next;

    logic [SOCKET_W-1:0]  socket_reg, socket_next;
    logic [ENABLED_W-1:0] enabled_reg, enabled_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     relay_out_reg, relay_out_next;
    logic [OUT_W-1:0]     exp_out_reg, exp_out_next;
    logic                 applied_out_reg, applied_out_next;

    logic [CNT_W-1:0]       cur_cnt;
    logic [CNT_W-1:0]       dec_cnt;
    logic                   sock_ok;
    logic [SOCK_W-1:0]      sock_idx;
    logic [CFG_W-1:0]       sel_minutes;
    logic [MAX_SOCKETS-1:0] relay_wide;
    logic [MAX_SOCKETS-1:0] exp_wide;
    logic                   out_free;

    // Shared decrement unit, fed by the sequencer index.
    assign cur_cnt = cnt_reg[idx_reg];
    assign dec_cnt = cur_cnt - CNT_W'(1);

    // Set request decode.
    assign sock_ok     = (32'(socket_reg) < 32'(SOCKETS));
    assign sock_idx    = SOCK_W'(socket_reg);
    assign sel_minutes = (32'(socket_reg) < 32'(NUM_CFG)) ? min_reg[socket_reg] : '0;

    // Only the low six sockets are visible on the result.
    assign relay_wide = MAX_SOCKETS'(relay_next);
    assign exp_wide   = MAX_SOCKETS'(exp_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        relay_next       = relay_reg;
        exp_next         = exp_reg;
        applied_next     = applied_reg;
        idx_next         = idx_reg;
        socket_next      = socket_reg;
        enabled_next     = enabled_reg;
        out_valid_next   = out_valid_reg && out_stall;
        relay_out_next   = relay_out_reg;
        exp_out_next     = exp_out_reg;
        applied_out_next = applied_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    socket_next  = socket;
                    enabled_next = enabled;
                    exp_next     = '0;
                    applied_next = 1'b0;
                    idx_next     = '0;
                    state_next   = (cmd == CMD_TICK) ? ST_TICK : ST_SET;
                end
            end
            ST_TICK:
            begin
                if (cur_cnt != CNT_STOPPED)
                begin
                    if (cur_cnt != '0)
                    begin
                        cnt_next[idx_reg] = dec_cnt;
                    end
                    else
                    begin
                        cnt_next[idx_reg]   = CNT_STOPPED;
                        relay_next[idx_reg] = 1'b0;
                        exp_next[idx_reg]   = 1'b1;
                    end
                end
                if (idx_reg == SOCK_W'(SOCKETS - 1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + SOCK_W'(1);
                end
            end
            ST_SET:
            begin
                if (sock_ok)
                begin
                    if (enabled_reg == VAL_ON)
                    begin
                        cnt_next[sock_idx]   = (sel_minutes != '0) ?
                                               minutes_to_ticks(sel_minutes) : CNT_STOPPED;
                        relay_next[sock_idx] = 1'b1;
                        applied_next         = 1'b1;
                    end
                    else
                    begin
                        cnt_next[sock_idx]   = CNT_STOPPED;
                        relay_next[sock_idx] = 1'b0;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    relay_out_next   = relay_wide[OUT_W-1:0];
                    exp_out_next     = exp_wide[OUT_W-1:0];
                    applied_out_next = applied_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            relay_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < SOCKETS; i++)
            begin
                cnt_reg[i] <= CNT_STOPPED;
            end
            for (int i = 0; i < NUM_CFG; i++)
            begin
                min_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            relay_reg     <= relay_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            if (cfg_we && (32'(cfg_index) < 32'(NUM_CFG)))
            begin
                min_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        exp_reg         <= exp_next;
        applied_reg     <= applied_next;
        socket_reg      <= socket_next;
        enabled_reg     <= enabled_next;
        relay_out_reg   <= relay_out_next;
        exp_out_reg     <= exp_out_next;
        applied_out_reg <= applied_out_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign relay_state   = relay_out_reg;
    assign expired_mask  = exp_out_reg;
    assign applied_value = applied_out_reg;

`ifndef SYNTHESIS
    // An expired socket must show its relay off in the same result.
    a_expired_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((expired_mask & relay_state) == '0))
        else $error("expired socket still shows its relay on");

    // A result comes from either a set or a tick, never both.
    a_set_or_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(applied_value && (expired_mask != '0)))
        else $error("result carries both an applied value and expiries");

    // The sequencer index never walks past the last socket.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(idx_reg) < 32'(SOCKETS))
        else $error("sequencer index out of range");

    // An accepted request blocks the input in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a request was accepted");
`endif

endmodule

`default_nettype wire
